// ===== hw/rtl/stfmt_pkg.sv =====
// Shared types, constants and the digit-to-segment table of the temperature formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package stfmt_pkg;

    localparam int InDataW  = 24;
    localparam int InUserW  = 1;
    localparam int OutDataW = 40;

    localparam int MagW = 14;

    localparam logic [7:0]      SegMinus = 8'h08;
    localparam logic [7:0]      SegHigh  = 8'h80;
    localparam logic [5:0]      RealBase = 6'd0;
    localparam logic [5:0]      SetBase  = 6'd32;
    localparam logic [MagW-1:0] MaxShown = 14'd9999;

    typedef enum logic [1:0] {
        ClsPos      = 2'd0,
        ClsNegSmall = 2'd1,
        ClsNegClamp = 2'd2
    } range_cls_t;

    typedef struct packed {
        logic [3:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [3:0] on;
    } digits_t;

    typedef struct packed {
        logic is_set;
        logic heat_icon_dark;
        logic blink_dark;
        logic key_active;
    } fmt_flags_t;

    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h77;
            4'd1:    s = 8'h24;
            4'd2:    s = 8'h5d;
            4'd3:    s = 8'h6d;
            4'd4:    s = 8'h2e;
            4'd5:    s = 8'h6b;
            4'd6:    s = 8'h7b;
            4'd7:    s = 8'h25;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stfmt_bcd.sv =====
// Range classification and decimal digit split of the signed temperature.
// Depends on stfmt_pkg.
`default_nettype none

module stfmt_bcd (
    input  wire logic signed [15:0]   temp_tenths,
    output stfmt_pkg::range_cls_t     cls,
    output stfmt_pkg::digits_t        digits
);
    import stfmt_pkg::*;

    logic [15:0]     neg_v;
    logic [MagW-1:0] mag;
    logic [9:0]      rem_hu;
    logic [6:0]      rem_te;

    always_comb
    begin
        neg_v = 16'(16'd0 - temp_tenths);
        if (!temp_tenths[15])
        begin
            cls = ClsPos;
            mag = (temp_tenths > $signed(16'(MaxShown))) ? MaxShown : temp_tenths[MagW-1:0];
        end
        else if (temp_tenths > -16'sd100)
        begin
            cls = ClsNegSmall;
            mag = neg_v[MagW-1:0];
        end
        else
        begin
            cls = ClsNegClamp;
            mag = '0;
        end
    end

    // split one decimal place per level by parallel compares
    always_comb
    begin
        digits.th = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (mag >= MagW'(k * 1000))
                digits.th = 4'(k);
        end
        rem_hu = 10'(mag - MagW'(32'(digits.th) * 1000));

        digits.hu = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_hu >= 10'(k * 100))
                digits.hu = 4'(k);
        end
        rem_te = 7'(rem_hu - 10'(32'(digits.hu) * 100));

        digits.te = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_te >= 7'(k * 10))
                digits.te = 4'(k);
        end
        digits.on = 4'(rem_te - 7'(32'(digits.te) * 10));
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stfmt_seg.sv =====
// Segment byte assembly: digit glyphs, blanking, icon and point bits, byte order.
// Depends on stfmt_pkg.
`default_nettype none

module stfmt_seg (
    input  wire stfmt_pkg::range_cls_t cls,
    input  wire stfmt_pkg::digits_t    digits,
    input  wire stfmt_pkg::fmt_flags_t flags,
    output logic [5:0]                 base_addr,
    output logic [7:0]                 byte_a,
    output logic [7:0]                 byte_b,
    output logic [7:0]                 byte_c,
    output logic [7:0]                 byte_d
);
    import stfmt_pkg::*;

    logic [7:0] p0, p1, p2, p3;

    always_comb
    begin
        unique case (cls)
            ClsPos:
            begin
                p0 = (digits.th != 4'd0) ? seg_digit(digits.th) : 8'h00;
                p1 = (digits.th != 4'd0 || digits.hu != 4'd0) ? seg_digit(digits.hu) : 8'h00;
                p2 = seg_digit(digits.te);
                p3 = seg_digit(digits.on);
            end
            ClsNegSmall:
            begin
                p0 = 8'h00;
                p1 = SegMinus;
                p2 = seg_digit(digits.te);
                p3 = seg_digit(digits.on);
            end
            ClsNegClamp:
            begin
                p0 = SegMinus;
                p1 = seg_digit(4'd1);
                p2 = seg_digit(4'd0);
                p3 = seg_digit(4'd0);
            end
            default:
            begin
                p0 = 8'h00;
                p1 = 8'h00;
                p2 = 8'h00;
                p3 = 8'h00;
            end
        endcase

        if (!flags.is_set)
        begin
            base_addr = RealBase;
            byte_a    = p0 | SegHigh;
            byte_b    = p1;
            byte_c    = flags.heat_icon_dark ? p2 : (p2 | SegHigh);
            byte_d    = p3 | SegHigh;
        end
        else if (flags.blink_dark && !flags.key_active)
        begin
            base_addr = SetBase;
            byte_a    = 8'h00;
            byte_b    = 8'h00;
            byte_c    = 8'h00;
            byte_d    = 8'h00;
        end
        else
        begin
            base_addr = SetBase;
            byte_a    = p3;
            byte_b    = p2 | SegHigh;
            byte_c    = p1;
            byte_d    = p0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/signed_temp_seven_segment_format.sv =====
// Top level of the signed temperature seven-segment formatter: stream ports,
// input and result registers. Depends on stfmt_pkg, stfmt_bcd and stfmt_seg.
//
// One word in, one word out, one word per cycle sustained while m_axis_tready
// is high. An accepted word is registered, split into decimal digits and turned
// into four segment bytes by combinational logic, and lands in the result
// register once it is empty or its word is taken. The input register and the
// result register form a two-deep pipeline; while the result register waits on
// the downstream ready, the input side takes one more word into the empty input
// register and then holds off until the result is taken.
`default_nettype none

module signed_temp_seven_segment_format (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] temp_tenths, [16] heat_icon_dark, [17] blink_dark, [18] key_active
    input  wire logic [stfmt_pkg::InDataW-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic [stfmt_pkg::InUserW-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [5:0] base_addr, [13:6] byte_a, [21:14] byte_b, [29:22] byte_c, [37:30] byte_d
    output logic [stfmt_pkg::OutDataW-1:0]      m_axis_tdata
);
    import stfmt_pkg::*;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic signed [15:0] temp_reg;
    fmt_flags_t        flags_reg;
    logic [5:0]        base_reg;
    logic [7:0]        byte_a_reg, byte_b_reg, byte_c_reg, byte_d_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic              s1_load;
    logic              s2_load;
    fmt_flags_t        flags_next;
    range_cls_t        cls;
    digits_t           digits;
    logic [5:0]        base_next;
    logic [7:0]        byte_a_next, byte_b_next, byte_c_next, byte_d_next;

    assign s2_ready      = !s2_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s1_load       = s_axis_tvalid && s1_ready;
    assign s2_load       = s1_valid_reg && s2_ready;
    assign s_axis_tready = s1_ready;

    assign flags_next.is_set         = s_axis_tuser[0];
    assign flags_next.heat_icon_dark = s_axis_tdata[16];
    assign flags_next.blink_dark     = s_axis_tdata[17];
    assign flags_next.key_active     = s_axis_tdata[18];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            temp_reg  <= s_axis_tdata[15:0];
            flags_reg <= flags_next;
        end
        if (s2_load)
        begin
            base_reg   <= base_next;
            byte_a_reg <= byte_a_next;
            byte_b_reg <= byte_b_next;
            byte_c_reg <= byte_c_next;
            byte_d_reg <= byte_d_next;
        end
    end

    stfmt_bcd u_bcd (
        .temp_tenths (temp_reg),
        .cls         (cls),
        .digits      (digits)
    );

    stfmt_seg u_seg (
        .cls       (cls),
        .digits    (digits),
        .flags     (flags_reg),
        .base_addr (base_next),
        .byte_a    (byte_a_next),
        .byte_b    (byte_b_next),
        .byte_c    (byte_c_next),
        .byte_d    (byte_d_next)
    );

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {2'b00, byte_d_reg, byte_c_reg, byte_b_reg, byte_a_reg, base_reg};

`ifndef ASSERT_OFF
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("pending word in input register dropped");

    a_base: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] == RealBase || m_axis_tdata[5:0] == SetBase))
        else $error("bad base address");

    a_degree: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == RealBase |-> m_axis_tdata[13])
        else $error("degree mark missing on real display");

    a_set_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == SetBase |->
            (m_axis_tdata[21] || m_axis_tdata[37:6] == 32'd0))
        else $error("set display point missing without blanking");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_signed_temp_seven_segment_format.sv =====
// Testbench for the signed temperature seven-segment formatter: drives temperature words
// with random idling and stalls, predicts every segment frame and checks it. Depends on stfmt_pkg.
`timescale 1ns / 1ps

typedef struct {
    logic [5:0] base_addr;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
} seg_frame_t;

class segment_ledger;
    seg_frame_t frames_due[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    function logic [7:0] glyph(int d);
        case (d)
            0: return 8'h77;
            1: return 8'h24;
            2: return 8'h5d;
            3: return 8'h6d;
            4: return 8'h2e;
            5: return 8'h6b;
            6: return 8'h7b;
            7: return 8'h25;
            8: return 8'h7f;
            default: return 8'h6f;
        endcase
    endfunction

    function seg_frame_t format_segments(logic is_set, logic [15:0] raw, logic icon_dark,
                                         logic blink, logic key);
        int         v;
        int         m;
        logic [7:0] p [4];
        seg_frame_t f;
        v = int'($signed(raw));
        if (v > 9999)
            v = 9999;
        if (v >= 0) begin
            p[0] = (v > 999) ? glyph((v / 1000) % 10) : 8'h00;
            p[1] = (v > 99) ? glyph((v / 100) % 10) : 8'h00;
            p[2] = glyph((v / 10) % 10);
            p[3] = glyph(v % 10);
        end else if (v > -100) begin
            m = -v;
            p[0] = 8'h00;
            p[1] = stfmt_pkg::SegMinus;
            p[2] = glyph((m / 10) % 10);
            p[3] = glyph(m % 10);
        end else begin
            p[0] = stfmt_pkg::SegMinus;
            p[1] = glyph(1);
            p[2] = glyph(0);
            p[3] = glyph(0);
        end
        if (!is_set) begin
            if (!icon_dark)
                p[2] = p[2] | stfmt_pkg::SegHigh;
            p[3] = p[3] | stfmt_pkg::SegHigh;
            p[0] = p[0] | stfmt_pkg::SegHigh;
            f.base_addr = stfmt_pkg::RealBase;
            f.byte_a = p[0];
            f.byte_b = p[1];
            f.byte_c = p[2];
            f.byte_d = p[3];
        end else begin
            p[2] = p[2] | stfmt_pkg::SegHigh;
            if (blink && !key) begin
                p[0] = 8'h00;
                p[1] = 8'h00;
                p[2] = 8'h00;
                p[3] = 8'h00;
            end
            f.base_addr = stfmt_pkg::SetBase;
            f.byte_a = p[3];
            f.byte_b = p[2];
            f.byte_c = p[1];
            f.byte_d = p[0];
        end
        return f;
    endfunction

    function void note_word(logic is_set, logic [15:0] raw, logic icon_dark, logic blink,
                            logic key);
        frames_due.push_back(format_segments(is_set, raw, icon_dark, blink, key));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_word(logic [stfmt_pkg::OutDataW-1:0] word);
        seg_frame_t want;
        if (frames_due.size() == 0) begin
            $display("%0t: unexpected frame, expected none actual %010h", $time, word);
            errors++;
            return;
        end
        want = frames_due.pop_front();
        compare_field("base_addr", {2'b00, want.base_addr}, {2'b00, word[5:0]});
        compare_field("byte_a", want.byte_a, word[13:6]);
        compare_field("byte_b", want.byte_b, word[21:14]);
        compare_field("byte_c", want.byte_c, word[29:22]);
        compare_field("byte_d", want.byte_d, word[37:30]);
    endfunction

    function int pending();
        return frames_due.size();
    endfunction
endclass

module tb_signed_temp_seven_segment_format;

    localparam int WatchdogLimit = 2000;
    localparam int LongHold      = 60;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [stfmt_pkg::InDataW-1:0]     s_axis_tdata;
    logic [stfmt_pkg::InUserW-1:0]     s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [stfmt_pkg::OutDataW-1:0]    m_axis_tdata;

    segment_ledger ledger;
    bit            idle_on;
    bit            long_hold_req;
    int            quiet_cycles;

    signed_temp_seven_segment_format u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input logic is_set, input logic [15:0] raw, input logic icon_dark,
                             input logic blink, input logic key);
        logic [stfmt_pkg::InDataW-1:0] word;
        int                            gap;
        word = '0;
        word[15:0] = raw;
        word[16] = icon_dark;
        word[17] = blink;
        word[18] = key;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= is_set;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        ledger.note_word(is_set, raw, icon_dark, blink, key);
    endtask

    task automatic send_random_word();
        logic [15:0] raw;
        int          sel;
        int          edges [9];
        edges = '{9999, 1000, 100, 10, 0, -10, -100, 32767, -32768};
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            raw = 16'($signed($urandom_range(0, 240)) - 120);
        else if (sel <= 5)
            raw = 16'($signed($urandom_range(0, 11200)) - 200);
        else if (sel == 6)
            raw = 16'(edges[$urandom_range(0, 8)] + $signed($urandom_range(0, 4)) - 2);
        else
            raw = 16'($urandom);
        send_word(1'($urandom_range(0, 1)), raw, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin : sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LongHold - 1) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 5);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : result_check
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                ledger.check_word(m_axis_tdata);
        end
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        ledger = new();
        idle_on = 1'b0;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // range extremes and sign boundaries
        send_word(1'b0, 16'sd32767, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, -16'sd32768, 1'b1, 1'b1, 1'b1);
        send_word(1'b0, 16'sd10000, 1'b0, 1'b1, 1'b0);
        send_word(1'b0, 16'sd9999, 1'b1, 1'b0, 1'b0);
        send_word(1'b1, 16'sd1000, 1'b0, 1'b0, 1'b0);
        send_word(1'b1, 16'sd999, 1'b1, 1'b0, 1'b1);
        send_word(1'b0, 16'sd100, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, 16'sd99, 1'b0, 1'b0, 1'b0);
        send_word(1'b1, 16'sd10, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, 16'sd9, 1'b1, 1'b0, 1'b0);
        send_word(1'b0, 16'sd0, 1'b0, 1'b0, 1'b0);
        send_word(1'b1, 16'sd0, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, -16'sd1, 1'b0, 1'b0, 1'b0);
        send_word(1'b1, -16'sd9, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, -16'sd10, 1'b1, 1'b0, 1'b0);
        send_word(1'b1, -16'sd99, 1'b0, 1'b0, 1'b1);
        send_word(1'b0, -16'sd100, 1'b0, 1'b0, 1'b0);
        send_word(1'b1, -16'sd101, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, 16'sd4567, 1'b0, 1'b0, 1'b0);
        send_word(1'b1, 16'sd8123, 1'b1, 1'b0, 1'b0);
        // set display blanking: dark phase blanks unless a key is active
        send_word(1'b1, 16'sd1234, 1'b0, 1'b1, 1'b0);
        send_word(1'b1, 16'sd1234, 1'b0, 1'b1, 1'b1);
        send_word(1'b1, -16'sd50, 1'b1, 1'b1, 1'b0);
        send_word(1'b0, 16'sd1234, 1'b1, 1'b1, 1'b0);

        idle_on = 1'b1;
        repeat (450) send_random_word();

        // hold the receiver off while words keep coming
        long_hold_req = 1'b1;
        repeat (50) send_random_word();

        drain();
        repeat (8) @(posedge clk);

        repeat (400) send_random_word();

        idle_on = 1'b0;
        repeat (250) send_random_word();

        drain();
        repeat (10) @(posedge clk);

        if (ledger.pending() != 0)
        begin
            $display("%0t: frames never arrived: %0d", $time, ledger.pending());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/stfmt_pkg.sv
hw/rtl/stfmt_bcd.sv
hw/rtl/stfmt_seg.sv
hw/rtl/signed_temp_seven_segment_format.sv
sim/tb_signed_temp_seven_segment_format.sv
